[hdl/urc_pkg.sv]
// shared types, constants and helpers for the ultrasonic ranging controller
// used by urc_dist_calc and ultrasonic_ranging_controller; no dependencies
`timescale 1ns / 1ps

package urc_pkg;

  localparam int SENSOR_COUNT = 3;
  localparam int TIME_BITS    = 32;
  localparam int CH_W         = 2;
  localparam int DIST_W       = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int ZONE_W       = 2;
  localparam int TRIG_W       = 3;
  localparam int SCALE_FRAC   = 16;

  // stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 64;

  localparam logic [DIST_W-1:0] DIST_MAX   = '1;
  localparam logic [CFG_W-1:0]  MIN_PERIOD = 16'd4;

  // sequencer steps: left trigger, right trigger, then all triggers low
  localparam logic [CFG_W-1:0] SEQ_STEP_LEFT  = 16'd1;
  localparam logic [CFG_W-1:0] SEQ_STEP_RIGHT = 16'd2;
  localparam logic [CFG_W-1:0] SEQ_STEP_IDLE  = 16'd3;

  // sensor channels
  localparam logic [CH_W-1:0] CH_BACK  = 2'd0;
  localparam logic [CH_W-1:0] CH_LEFT  = 2'd1;
  localparam logic [CH_W-1:0] CH_RIGHT = 2'd2;

  // trigger level vectors: bit 0 back, bit 1 left, bit 2 right
  localparam logic [TRIG_W-1:0] TRIG_NONE  = 3'b000;
  localparam logic [TRIG_W-1:0] TRIG_BACK  = 3'b001;
  localparam logic [TRIG_W-1:0] TRIG_LEFT  = 3'b010;
  localparam logic [TRIG_W-1:0] TRIG_RIGHT = 3'b100;

  // register reset values
  localparam logic [CFG_W-1:0] RST_TRIGGER_PERIOD  = 16'd2000;
  localparam logic [CFG_W-1:0] RST_REPORT_INTERVAL = 16'd10000;
  localparam logic [CFG_W-1:0] RST_NEAR_LIMIT      = 16'd5;
  localparam logic [CFG_W-1:0] RST_MID_LIMIT       = 16'd10;
  localparam logic [CFG_W-1:0] RST_FAR_LIMIT       = 16'd20;
  localparam logic [CFG_W-1:0] RST_SCALE_Q16       = 16'd1124;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_PERIOD  = 3'd0,
    REG_REPORT_INTERVAL = 3'd1,
    REG_NEAR_LIMIT      = 3'd2,
    REG_MID_LIMIT       = 3'd3,
    REG_FAR_LIMIT       = 3'd4,
    REG_SCALE_Q16       = 3'd5
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_TICK = 1'b0,
    KIND_ECHO = 1'b1
  } kind_t;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_CLEAR = 2'd0,
    ZONE_FAR   = 2'd1,
    ZONE_MID   = 2'd2,
    ZONE_NEAR  = 2'd3
  } zone_t;

  typedef struct packed {
    logic [CFG_W-1:0] trigger_period;
    logic [CFG_W-1:0] report_interval;
    logic [CFG_W-1:0] near_limit_cm;
    logic [CFG_W-1:0] mid_limit_cm;
    logic [CFG_W-1:0] far_limit_cm;
    logic [CFG_W-1:0] scale_q16;
  } cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic [CH_W-1:0]      channel;
    logic                 level;
    logic [TIME_BITS-1:0] time_us;
  } item_t;

  function automatic zone_t zone_of(input logic [DIST_W-1:0] d, input cfg_t c);
    zone_t z;
    if (d <= c.near_limit_cm) begin
      z = ZONE_NEAR;
    end else if (d <= c.mid_limit_cm) begin
      z = ZONE_MID;
    end else if (d <= c.far_limit_cm) begin
      z = ZONE_FAR;
    end else begin
      z = ZONE_CLEAR;
    end
    return z;
  endfunction

endpackage

[hdl/urc_dist_calc.sv]
// echo time to distance: wrapped elapsed time times q0.16 scale, saturated
// depends on urc_pkg
`timescale 1ns / 1ps

module urc_dist_calc (
  input  logic [urc_pkg::TIME_BITS-1:0] time_us,
  input  logic [urc_pkg::TIME_BITS-1:0] echo_start,
  input  logic [urc_pkg::CFG_W-1:0]     scale_q16,
  output logic [urc_pkg::DIST_W-1:0]    dist_cm
);
  import urc_pkg::*;

  localparam int PROD_W = TIME_BITS + CFG_W;

  logic [TIME_BITS-1:0] elapsed;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-SCALE_FRAC-1:0] whole;

  // elapsed wraps modulo the timestamp width
  assign elapsed = time_us - echo_start;
  assign prod    = PROD_W'(elapsed) * PROD_W'(scale_q16);
  assign whole   = prod[PROD_W-1:SCALE_FRAC];

  // saturate anything past the distance range
  assign dist_cm = (whole > (PROD_W-SCALE_FRAC)'(DIST_MAX)) ? DIST_MAX
                                                          : whole[DIST_W-1:0];

endmodule

[hdl/ultrasonic_ranging_controller.sv]
// three-channel ultrasonic ranger: trigger sequencer, echo timing, periodic report
// depends on urc_pkg and urc_dist_calc
// an accepted beat sits in the input register until the result register can take it
// throughput: one item per cycle; the input register drains whenever the result slot frees
// reset (rst, synchronous): registers back to defaults, counters zero, back trigger high,
// echo start times and distances zero, both stream sides empty
`timescale 1ns / 1ps

module ultrasonic_ranging_controller (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] channel, [2] level, [34:3] time_us, [39:35] zero
  input  logic [urc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic [0:0]                    s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] trig_back, [1] trig_left, [2] trig_right, [18:3] dist_left_cm,
  // [34:19] dist_right_cm, [50:35] dist_back_cm, [52:51] zone_left,
  // [54:53] zone_right, [56:55] zone_back, [63:57] zero
  output logic [urc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] report_valid
  output logic [0:0]                    m_axis_tuser,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [urc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urc_pkg::CFG_W-1:0]     cfg_data
);
  import urc_pkg::*;

  // configuration registers
  cfg_t cfg;

  // input register
  logic  in_valid;
  item_t in_item;

  // ranging state
  logic [CFG_W-1:0]     seq_ticks, seq_ticks_next;
  logic [CFG_W-1:0]     rep_ticks, rep_ticks_next;
  logic [TRIG_W-1:0]    trig_levels, trig_next;
  logic [TIME_BITS-1:0] echo_start [SENSOR_COUNT];
  logic [DIST_W-1:0]    distance   [SENSOR_COUNT];

  // result register
  logic              out_valid;
  logic [TRIG_W-1:0] out_trig;
  logic              out_report;
  logic [DIST_W-1:0] out_left_cm, out_right_cm, out_back_cm;
  zone_t             out_zone_left, out_zone_right, out_zone_back;

  logic                 out_free;
  logic                 fire;
  logic                 in_take;
  logic                 report_hit;
  logic                 ch_ok;
  logic [CFG_W-1:0]     period;
  logic [CFG_W-1:0]     seq_inc;
  logic [CFG_W-1:0]     rep_inc;
  logic [TIME_BITS-1:0] start_sel;
  logic [DIST_W-1:0]    dist_new;

  // ---------------------------------------------------------------
  // handshakes: the result slot frees when empty or being taken, the
  // input register refills in the same cycle it drains
  // ---------------------------------------------------------------
  assign out_free      = !out_valid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_period  <= RST_TRIGGER_PERIOD;
      cfg.report_interval <= RST_REPORT_INTERVAL;
      cfg.near_limit_cm   <= RST_NEAR_LIMIT;
      cfg.mid_limit_cm    <= RST_MID_LIMIT;
      cfg.far_limit_cm    <= RST_FAR_LIMIT;
      cfg.scale_q16       <= RST_SCALE_Q16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRIGGER_PERIOD:  cfg.trigger_period  <= cfg_data;
        REG_REPORT_INTERVAL: cfg.report_interval <= cfg_data;
        REG_NEAR_LIMIT:      cfg.near_limit_cm   <= cfg_data;
        REG_MID_LIMIT:       cfg.mid_limit_cm    <= cfg_data;
        REG_FAR_LIMIT:       cfg.far_limit_cm    <= cfg_data;
        REG_SCALE_Q16:       cfg.scale_q16       <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: unpack the beat on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.kind    <= kind_t'(s_axis_tuser[0]);
      in_item.channel <= s_axis_tdata[CH_W-1:0];
      in_item.level   <= s_axis_tdata[CH_W];
      in_item.time_us <= s_axis_tdata[CH_W+1 +: TIME_BITS];
    end
  end

  // ---------------------------------------------------------------
  // echo path: start time of the addressed channel feeds the distance unit
  // ---------------------------------------------------------------
  assign ch_ok = in_item.channel < CH_W'(SENSOR_COUNT);

  always_comb begin
    start_sel = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (in_item.channel == CH_W'(i)) begin
        start_sel = echo_start[i];
      end
    end
  end

  urc_dist_calc u_dist (
    .time_us    (in_item.time_us),
    .echo_start (start_sel),
    .scale_q16  (cfg.scale_q16),
    .dist_cm    (dist_new)
  );

  // ---------------------------------------------------------------
  // tick path: trigger sequencer and report counter
  // steps 1..3 walk left, right, idle; a count at or past the period
  // (never below four) restarts with the back trigger
  // ---------------------------------------------------------------
  assign period  = (cfg.trigger_period < MIN_PERIOD) ? MIN_PERIOD : cfg.trigger_period;
  assign seq_inc = seq_ticks + CFG_W'(1);
  assign rep_inc = (rep_ticks == DIST_MAX) ? rep_ticks : rep_ticks + CFG_W'(1);

  always_comb begin
    seq_ticks_next = seq_ticks;
    rep_ticks_next = rep_ticks;
    trig_next      = trig_levels;
    report_hit     = 1'b0;
    if (in_item.kind == KIND_TICK) begin
      seq_ticks_next = seq_inc;
      rep_ticks_next = rep_inc;
      priority if (seq_inc == SEQ_STEP_LEFT) begin
        trig_next = TRIG_LEFT;
      end else if (seq_inc == SEQ_STEP_RIGHT) begin
        trig_next = TRIG_RIGHT;
      end else if (seq_inc == SEQ_STEP_IDLE) begin
        trig_next = TRIG_NONE;
      end else if (seq_inc >= period) begin
        trig_next      = trig_levels | TRIG_BACK;
        seq_ticks_next = '0;
      end else begin
        trig_next = trig_levels;
      end
      // counter saturates, so an interval of all ones never reports
      if (rep_inc > cfg.report_interval) begin
        report_hit     = 1'b1;
        rep_ticks_next = '0;
      end
    end
  end

  // state update as the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_ticks   <= '0;
      rep_ticks   <= '0;
      trig_levels <= TRIG_BACK;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        echo_start[i] <= '0;
        distance[i]   <= '0;
      end
    end else if (fire) begin
      seq_ticks   <= seq_ticks_next;
      rep_ticks   <= rep_ticks_next;
      trig_levels <= trig_next;
      // echo edges on a channel past the sensor count are dropped
      if (in_item.kind == KIND_ECHO && ch_ok) begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          if (in_item.channel == CH_W'(i)) begin
            if (in_item.level) begin
              echo_start[i] <= in_item.time_us;
            end else begin
              distance[i] <= dist_new;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // result register; distance and zone fields are zero unless reporting
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_trig   <= trig_next;
      out_report <= report_hit;
      if (report_hit) begin
        out_left_cm    <= distance[CH_LEFT];
        out_right_cm   <= distance[CH_RIGHT];
        out_back_cm    <= distance[CH_BACK];
        out_zone_left  <= zone_of(distance[CH_LEFT], cfg);
        out_zone_right <= zone_of(distance[CH_RIGHT], cfg);
        out_zone_back  <= zone_of(distance[CH_BACK], cfg);
      end else begin
        out_left_cm    <= '0;
        out_right_cm   <= '0;
        out_back_cm    <= '0;
        out_zone_left  <= ZONE_CLEAR;
        out_zone_right <= ZONE_CLEAR;
        out_zone_back  <= ZONE_CLEAR;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_report;
  assign m_axis_tdata  = {7'b0,
                          out_zone_back, out_zone_right, out_zone_left,
                          out_back_cm, out_right_cm, out_left_cm,
                          out_trig};

`ifndef SYNTHESIS
  // at most one trigger pin is ever high
  a_trig_onehot0: assert property (@(posedge clk) disable iff (rst)
    $onehot0(trig_levels))
    else $error("more than one trigger high");

  // a report clears the report counter
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    fire && report_hit |=> rep_ticks == '0)
    else $error("report counter not cleared after report");

  // echo edges leave the sequencer and report counter alone
  a_echo_no_tick: assert property (@(posedge clk) disable iff (rst)
    fire && in_item.kind == KIND_ECHO |=> $stable(seq_ticks) && $stable(rep_ticks))
    else $error("echo edge moved a tick counter");

  // a held item stays in the input register while the result slot is busy
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(in_item))
    else $error("input item lost while stalled");
`endif

endmodule

[tb/tb.sv]
// self-checking testbench for ultrasonic_ranging_controller: stream stimulus, config writes,
// a scoreboard class with its own model of the sequencer, echo timing and reports
// depends on urc_pkg and the controller rtl only
`timescale 1ns / 1ps

module tb;
  import urc_pkg::*;

  // index codes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
  // channel code beyond the last sensor
  localparam logic [CH_W-1:0]      CH_UNUSED       = 2'd3;
  localparam logic                 LEVEL_FALL      = 1'b0;
  localparam logic                 LEVEL_RISE      = 1'b1;
  localparam int                   HOLD_TICKS      = 24;

  // one expected result beat
  typedef struct packed {
    logic [TRIG_W-1:0] trig;
    logic              report;
    logic [DIST_W-1:0] left_cm;
    logic [DIST_W-1:0] right_cm;
    logic [DIST_W-1:0] back_cm;
    zone_t             zone_left;
    zone_t             zone_right;
    zone_t             zone_back;
  } ranging_result_t;

  // mirrors the controller state and queues the expected result of every accepted beat
  class ranging_scoreboard;
    cfg_t                 regs;
    logic [CFG_W-1:0]     seq_ticks;
    logic [CFG_W-1:0]     report_ticks;
    logic [TRIG_W-1:0]    trig_levels;
    logic [TIME_BITS-1:0] echo_start [SENSOR_COUNT];
    logic [DIST_W-1:0]    dist_cm [SENSOR_COUNT];
    ranging_result_t      expected_results [$];
    int                   errors;

    function new();
      regs.trigger_period  = 16'd2000;
      regs.report_interval = 16'd10000;
      regs.near_limit_cm   = 16'd5;
      regs.mid_limit_cm    = 16'd10;
      regs.far_limit_cm    = 16'd20;
      regs.scale_q16       = 16'd1124;
      seq_ticks    = '0;
      report_ticks = '0;
      trig_levels  = TRIG_BACK;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        echo_start[i] = '0;
        dist_cm[i]    = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_TRIGGER_PERIOD:  regs.trigger_period  = val;
        REG_REPORT_INTERVAL: regs.report_interval = val;
        REG_NEAR_LIMIT:      regs.near_limit_cm   = val;
        REG_MID_LIMIT:       regs.mid_limit_cm    = val;
        REG_FAR_LIMIT:       regs.far_limit_cm    = val;
        REG_SCALE_Q16:       regs.scale_q16       = val;
        default: ;
      endcase
    endfunction

    // elapsed microseconds to centimetres, split in halves so nothing overflows
    function logic [DIST_W-1:0] echo_to_cm(logic [TIME_BITS-1:0] elapsed);
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] cm;
      hi = 64'(elapsed[31:16]);
      lo = 64'(elapsed[15:0]);
      cm = hi * regs.scale_q16 + ((lo * regs.scale_q16) >> 16);
      if (cm > 64'hFFFF) begin
        return DIST_MAX;
      end
      return cm[DIST_W-1:0];
    endfunction

    function zone_t proximity(logic [DIST_W-1:0] d);
      if (d <= regs.near_limit_cm) begin
        return ZONE_NEAR;
      end else if (d <= regs.mid_limit_cm) begin
        return ZONE_MID;
      end else if (d <= regs.far_limit_cm) begin
        return ZONE_FAR;
      end
      return ZONE_CLEAR;
    endfunction

    function void note_item(item_t it);
      ranging_result_t  r;
      logic [CFG_W-1:0] period;
      logic             report;
      report = 1'b0;
      if (it.kind == KIND_TICK) begin
        period    = (regs.trigger_period < MIN_PERIOD) ? MIN_PERIOD : regs.trigger_period;
        seq_ticks = seq_ticks + 16'd1;
        if (report_ticks != 16'hFFFF) begin
          report_ticks = report_ticks + 16'd1;
        end
        // fixed steps win over the restart
        if (seq_ticks == SEQ_STEP_LEFT) begin
          trig_levels = TRIG_LEFT;
        end else if (seq_ticks == SEQ_STEP_RIGHT) begin
          trig_levels = TRIG_RIGHT;
        end else if (seq_ticks == SEQ_STEP_IDLE) begin
          trig_levels = TRIG_NONE;
        end else if (seq_ticks >= period) begin
          trig_levels = trig_levels | TRIG_BACK;
          seq_ticks   = '0;
        end
        if (report_ticks > regs.report_interval) begin
          report       = 1'b1;
          report_ticks = '0;
        end
      end else if (it.channel < SENSOR_COUNT) begin
        if (it.level) begin
          echo_start[it.channel] = it.time_us;
        end else begin
          dist_cm[it.channel] = echo_to_cm(it.time_us - echo_start[it.channel]);
        end
      end
      r        = '0;
      r.trig   = trig_levels;
      r.report = report;
      if (report) begin
        r.left_cm    = dist_cm[CH_LEFT];
        r.right_cm   = dist_cm[CH_RIGHT];
        r.back_cm    = dist_cm[CH_BACK];
        r.zone_left  = proximity(dist_cm[CH_LEFT]);
        r.zone_right = proximity(dist_cm[CH_RIGHT]);
        r.zone_back  = proximity(dist_cm[CH_BACK]);
      end
      expected_results.push_back(r);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data, logic [0:0] user);
      ranging_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no expected result pending");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare("trig_back", want.trig[0], data[0]);
      compare("trig_left", want.trig[1], data[1]);
      compare("trig_right", want.trig[2], data[2]);
      compare("report_valid", want.report, user[0]);
      compare("dist_left_cm", want.left_cm, data[18:3]);
      compare("dist_right_cm", want.right_cm, data[34:19]);
      compare("dist_back_cm", want.back_cm, data[50:35]);
      compare("zone_left", want.zone_left, data[52:51]);
      compare("zone_right", want.zone_right, data[54:53]);
      compare("zone_back", want.zone_back, data[56:55]);
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_W-1:0]      cfg_data      = '0;

  ranging_scoreboard sb;

  // sender burst bookkeeping; steady turns sender gaps off for a whole phase
  int   burst_left = 0;
  logic steady     = 1'b0;

  // receiver stall pattern, redrawn whenever the pattern position wraps to zero
  logic [15:0] stall_pat  = '1;
  int          stall_odds = 0;
  int          pat_pos    = 0;

  ultrasonic_ranging_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // receiver: odds 0 never stalls, higher odds stall more often
  always @(negedge clk) begin
    if (pat_pos == 0) begin
      stall_odds = $urandom_range(0, 3);
      case (stall_odds)
        1:       stall_pat = 16'($urandom | $urandom);
        2:       stall_pat = 16'($urandom);
        default: stall_pat = 16'($urandom & $urandom);
      endcase
    end
    m_axis_tready <= (stall_odds == 0) || stall_pat[pat_pos % 16];
    pat_pos = (pat_pos + 1) % 48;
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // one input beat; entered and left at a falling edge
  task automatic send_item(input kind_t k, input logic [CH_W-1:0] ch, input logic lvl,
                           input logic [TIME_BITS-1:0] t);
    item_t it;
    it.kind    = k;
    it.channel = ch;
    it.level   = lvl;
    it.time_us = t;
    if (!steady && burst_left == 0) begin
      // gap between bursts
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, t, lvl, ch};
    s_axis_tuser  <= k;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(it);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // tick beats carry random junk in the unused fields
  task automatic send_tick();
    send_item(KIND_TICK, CH_W'($urandom), 1'($urandom), $urandom);
  endtask

  // stop sending and wait until every expected beat has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] interval,
                            input logic [CFG_W-1:0] near_cm, input logic [CFG_W-1:0] mid_cm,
                            input logic [CFG_W-1:0] far_cm, input logic [CFG_W-1:0] scale);
    write_reg(REG_TRIGGER_PERIOD, period);
    write_reg(REG_REPORT_INTERVAL, interval);
    write_reg(REG_NEAR_LIMIT, near_cm);
    write_reg(REG_MID_LIMIT, mid_cm);
    write_reg(REG_FAR_LIMIT, far_cm);
    write_reg(REG_SCALE_Q16, scale);
  endtask

  // mostly ticks and well-formed rising/falling pairs, the rest raw echo noise
  task automatic run_random(input int count);
    int                   sent;
    int                   pick;
    int                   span;
    logic [CH_W-1:0]      ch;
    logic [TIME_BITS-1:0] t0;
    logic [TIME_BITS-1:0] delta;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_tick();
        sent++;
      end else if (pick < 85) begin
        ch   = CH_W'($urandom_range(0, SENSOR_COUNT - 1));
        t0   = $urandom;
        span = $urandom_range(0, 9);
        if (span < 6) begin
          delta = $urandom_range(0, 2000);
        end else if (span < 8) begin
          delta = $urandom_range(0, 70000);
        end else if (span == 8) begin
          delta = $urandom;
        end else begin
          delta = '0;
        end
        send_item(KIND_ECHO, ch, LEVEL_RISE, t0);
        // sometimes a tick lands inside the echo pulse
        if ($urandom_range(0, 9) < 3) begin
          send_tick();
          sent++;
        end
        send_item(KIND_ECHO, ch, LEVEL_FALL, t0 + delta);
        sent += 2;
      end else begin
        send_item(KIND_ECHO, CH_W'($urandom_range(0, 3)), 1'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    logic [CFG_W-1:0] near_cm;
    logic [CFG_W-1:0] mid_cm;
    logic [CFG_W-1:0] far_cm;
    logic [CFG_W-1:0] scale;
    sb = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: falling edge with no rising one uses start time zero
    send_item(KIND_ECHO, CH_BACK, LEVEL_FALL, 32'd1000);
    // first three sequencer steps: left, right, all low
    send_tick();
    send_tick();
    send_tick();
    // widest pulse saturates the distance
    send_item(KIND_ECHO, CH_LEFT, LEVEL_RISE, 32'h0000_0000);
    send_item(KIND_ECHO, CH_LEFT, LEVEL_FALL, 32'hFFFF_FFFF);
    // timestamp wraps inside the pulse
    send_item(KIND_ECHO, CH_RIGHT, LEVEL_RISE, 32'hFFFF_FF00);
    send_item(KIND_ECHO, CH_RIGHT, LEVEL_FALL, 32'h0000_0100);
    // edges on a channel with no sensor are dropped
    send_item(KIND_ECHO, CH_UNUSED, LEVEL_RISE, $urandom);
    send_item(KIND_ECHO, CH_UNUSED, LEVEL_FALL, $urandom);
    send_tick();
    drain();

    // period below the minimum, report on every tick, widest zone bands
    set_config(16'd0, 16'd0, 16'd0, 16'd10, 16'hFFFF, 16'hFFFF);
    // writes to unmapped indexes must leave every register alone
    write_reg(REG_UNMAPPED_LO, 16'd1);
    write_reg(REG_UNMAPPED_HI, 16'hFFFF);
    repeat (6) send_tick();
    send_item(KIND_ECHO, CH_BACK, LEVEL_RISE, 32'd5);
    send_item(KIND_ECHO, CH_BACK, LEVEL_FALL, 32'd5);
    send_tick();
    send_item(KIND_ECHO, CH_LEFT, LEVEL_RISE, 32'd100);
    send_item(KIND_ECHO, CH_LEFT, LEVEL_FALL, 32'd102);
    send_tick();
    drain();

    // random phases, each under its own register set
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(CFG_W'($urandom_range(4, 40)), CFG_W'($urandom_range(0, 15)),
                      16'd5, 16'd10, 16'd20, 16'd1124);
        1: set_config(CFG_W'($urandom_range(0, 3)), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: set_config(16'hFFFF, CFG_W'($urandom_range(0, 10)), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF);
        default: begin
          near_cm = CFG_W'($urandom_range(0, 40));
          mid_cm  = CFG_W'(near_cm + $urandom_range(0, 40));
          far_cm  = CFG_W'(mid_cm + $urandom_range(0, 60));
          // now and then the bands come in any order
          if ($urandom_range(0, 3) == 0) begin
            near_cm = CFG_W'($urandom);
            mid_cm  = CFG_W'($urandom);
            far_cm  = CFG_W'($urandom);
          end
          scale = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(500, 3000));
          set_config(CFG_W'($urandom_range(0, 64)), CFG_W'($urandom_range(0, 20)), near_cm,
                     mid_cm, far_cm, scale);
        end
      endcase
      steady = ($urandom_range(0, 4) == 0);
      run_random(64);
      drain();
    end
    steady = 1'b0;

    // longest period and interval: no report and no restart over a short run
    set_config(16'hFFFF, 16'hFFFF, CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
               CFG_W'($urandom));
    repeat (HOLD_TICKS) send_tick();
    drain();
    // interval lowered below the running count reports on the next tick
    write_reg(REG_REPORT_INTERVAL, 16'd3);
    repeat (3) send_tick();
    drain();
    // period lowered below the running count restarts the cycle at once
    write_reg(REG_TRIGGER_PERIOD, 16'd4);
    repeat (6) send_tick();
    drain();

    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
